@@ src/kseq_pkg.sv @@
`default_nettype none

package kseq_pkg;

   // Field widths of the item and result beats.
   localparam int KEY_W       = 8;
   localparam int OPCODE_W    = 3;
   localparam int STAMP_W     = 32;
   localparam int RSP_COUNT_W = 16;

   // Sizes of the stores.
   localparam int NUM_KEYS    = 2 ** KEY_W;
   localparam int QUEUE_DEPTH = 16;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int COUNT_WIDTH = 16;
   localparam int NUM_MODS    = 6;

   // Operation codes.
   localparam logic [OPCODE_W-1:0] OP_SCAN       = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_POP        = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_READ_DOWN  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_READ_UP    = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_FLUSH      = 3'd4;

   // Scan code set 1 bytes with a special meaning.
   localparam logic [KEY_W-1:0] SC_EXT_PREFIX   = 8'hE0;
   localparam logic [KEY_W-1:0] SC_PAUSE_PREFIX = 8'hE1;
   localparam logic [KEY_W-1:0] SC_PAUSE_MAKE   = 8'h1D;
   localparam logic [KEY_W-1:0] SC_PAUSE_BREAK  = 8'h9D;
   localparam logic [KEY_W-1:0] SC_SELF_TEST    = 8'hAA;
   localparam logic [KEY_W-1:0] PAUSE_CODE      = 8'd97;
   localparam logic [1:0]       PAUSE_BYTES     = 2'd2;

   // Modifier key codes.
   localparam logic [KEY_W-1:0] MOD_LSHIFT = 8'h2A;
   localparam logic [KEY_W-1:0] MOD_RSHIFT = 8'h36;
   localparam logic [KEY_W-1:0] MOD_LALT   = 8'h38;
   localparam logic [KEY_W-1:0] MOD_RALT   = 8'hB8;
   localparam logic [KEY_W-1:0] MOD_LCTRL  = 8'h1D;
   localparam logic [KEY_W-1:0] MOD_RCTRL  = 8'h9D;

   // Work held for the work stage of an item.
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_MAKE,
      ACT_BREAK,
      ACT_POP,
      ACT_READ_DOWN,
      ACT_READ_UP,
      ACT_FLUSH
   } action_type;

   // One entry of the per-key store.
   typedef struct packed {
      logic                   pressed;
      logic [COUNT_WIDTH-1:0] down_count;
      logic [COUNT_WIDTH-1:0] up_count;
   } key_entry_type;

   // One entry of the key queue.
   typedef struct packed {
      logic               ctrled;
      logic               alted;
      logic               shifted;
      logic [KEY_W-1:0]   code;
      logic [STAMP_W-1:0] stamp;
   } queue_entry_type;

   // Counter increment that stops at the all-ones value.
   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
      logic [COUNT_WIDTH-1:0] r;
      if (c == {COUNT_WIDTH{1'b1}}) begin
         r = c;
      end else begin
         r = c + 1'b1;
      end
      return r;
   endfunction

   // Next slot of the ring.
   function automatic logic [QPTR_W-1:0] ring_next(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] r;
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   // One-hot position of a modifier key: lshift, rshift, lalt, ralt, lctrl, rctrl.
   function automatic logic [NUM_MODS-1:0] mod_mask(input logic [KEY_W-1:0] code);
      logic [NUM_MODS-1:0] m;
      m = '0;
      m[0] = (code == MOD_LSHIFT);
      m[1] = (code == MOD_RSHIFT);
      m[2] = (code == MOD_LALT);
      m[3] = (code == MOD_RALT);
      m[4] = (code == MOD_LCTRL);
      m[5] = (code == MOD_RCTRL);
      return m;
   endfunction

endpackage

`default_nettype wire

@@ src/keyboard_scancode_event_queue_core.sv @@
`default_nettype none

// Scan code set 1 decoder with a key event queue. Opcode 0 feeds one keyboard
// byte (E0 marks an extended key, the E1 sequence gives Pause make and break),
// 1 pops the oldest queued key, 2 and 3 read and clear a key's down or up
// counter, 4 flushes the queue, the key map and all counters. The queue keeps
// up to 15 keys and drops make events while full. An item's accept cycle reads
// the per-key memory and the queue slot at the head; the work stage then writes
// back and loads the result register once that register is free or its beat is
// taken. A new beat is taken only after the work stage is done, so a waiting
// result holds up the next item. After reset the block is ready at once, as the
// key memory is cleared through per-key valid bits and needs no sweep.
module keyboard_scancode_event_queue_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [kseq_pkg::OPCODE_W-1:0]   req_opcode,
   input  wire logic [kseq_pkg::KEY_W-1:0]      req_scan_byte,
   input  wire logic [kseq_pkg::STAMP_W-1:0]    req_timestamp,
   input  wire logic [kseq_pkg::KEY_W-1:0]      req_key_index,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_key_valid,
   output logic [kseq_pkg::KEY_W-1:0]           rsp_key_code,
   output logic                                 rsp_key_shift,
   output logic                                 rsp_key_alt,
   output logic                                 rsp_key_ctrl,
   output logic [kseq_pkg::STAMP_W-1:0]         rsp_key_time,
   output logic [kseq_pkg::RSP_COUNT_W-1:0]     rsp_count_value,
   output logic                                 rsp_queue_not_empty,
   output logic [kseq_pkg::KEY_W-1:0]           rsp_last_pressed_key,
   output logic [kseq_pkg::KEY_W-1:0]           rsp_last_released_key,
   input  wire logic                            csr_wr_en,
   input  wire logic                            csr_wr_data
);
   import kseq_pkg::*;

   logic repeat_en_ff;

   // Decode state.
   logic       prefix_ff;
   logic       prefix_in;
   logic [1:0] pause_ff;
   logic [1:0] pause_in;

   // Accept stage.
   logic             req_accept;
   action_type       act_in;
   logic [KEY_W-1:0] key_in;

   // Work stage.
   logic               busy_ff;
   action_type         act_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [STAMP_W-1:0] stamp_ff;
   logic               done;

   // Per-key store.
   key_entry_type key_rd;
   key_entry_type key_wr;
   logic          key_wr_en;
   logic          key_clear;

   // Queue memory and pointers.
   queue_entry_type q_mem [QUEUE_DEPTH];
   queue_entry_type q_rd_ff;
   queue_entry_type q_wr;
   logic            q_wr_en;
   logic [QPTR_W-1:0] head_ff;
   logic [QPTR_W-1:0] head_in;
   logic [QPTR_W-1:0] tail_ff;
   logic [QPTR_W-1:0] tail_in;

   logic [NUM_MODS-1:0] mods_ff;
   logic [NUM_MODS-1:0] mods_in;
   logic [KEY_W-1:0]    last_pressed_ff;
   logic [KEY_W-1:0]    last_pressed_in;
   logic [KEY_W-1:0]    last_released_ff;
   logic [KEY_W-1:0]    last_released_in;

   // Result beat.
   logic                   rsp_valid_ff;
   logic                   out_key_valid;
   queue_entry_type        out_entry;
   logic [COUNT_WIDTH-1:0] out_count;
   logic                   rsp_key_valid_ff;
   queue_entry_type        rsp_entry_ff;
   logic [RSP_COUNT_W-1:0] rsp_count_ff;
   logic                   rsp_not_empty_ff;
   logic [KEY_W-1:0]       rsp_last_pressed_ff;
   logic [KEY_W-1:0]       rsp_last_released_ff;

   assign req_ready  = ~busy_ff;
   assign req_accept = req_valid & req_ready;
   assign done       = busy_ff & (~rsp_valid_ff | rsp_ready);

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_en_ff <= 1'b1;
      end else if (csr_wr_en) begin
         repeat_en_ff <= csr_wr_data;
      end
   end

   // Byte decoding: prefix and Pause tracking, and the key to look up.
   always_comb begin
      prefix_in = prefix_ff;
      pause_in  = pause_ff;
      act_in    = ACT_NONE;
      key_in    = req_key_index;
      unique case (req_opcode)
         OP_SCAN: begin
            priority if (req_scan_byte == SC_EXT_PREFIX) begin
               prefix_in = 1'b1;
            end else if (pause_ff != 2'd0) begin
               pause_in = pause_ff - 2'd1;
               if (req_scan_byte == SC_PAUSE_MAKE) begin
                  act_in    = ACT_MAKE;
                  key_in    = PAUSE_CODE;
                  prefix_in = 1'b0;
               end else if (req_scan_byte == SC_PAUSE_BREAK) begin
                  act_in    = ACT_BREAK;
                  key_in    = PAUSE_CODE;
                  prefix_in = 1'b0;
               end
            end else if (req_scan_byte == SC_PAUSE_PREFIX) begin
               pause_in = PAUSE_BYTES;
            end else begin
               act_in    = req_scan_byte[KEY_W-1] ? ACT_BREAK : ACT_MAKE;
               key_in    = {prefix_ff, req_scan_byte[KEY_W-2:0]};
               prefix_in = 1'b0;
            end
         end
         OP_POP:       act_in = ACT_POP;
         OP_READ_DOWN: act_in = ACT_READ_DOWN;
         OP_READ_UP:   act_in = ACT_READ_UP;
         OP_FLUSH:     act_in = ACT_FLUSH;
         default:      act_in = ACT_NONE;
      endcase
   end

   // Accept stage registers and the busy flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         prefix_ff <= 1'b0;
         pause_ff  <= 2'd0;
         act_ff    <= ACT_NONE;
      end else begin
         if (req_accept) begin
            busy_ff   <= 1'b1;
            prefix_ff <= prefix_in;
            pause_ff  <= pause_in;
            act_ff    <= act_in;
         end else if (done) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         key_ff   <= key_in;
         stamp_ff <= req_timestamp;
      end
   end

   kseq_key_store u_key_store (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_accept),
      .rd_addr   (key_in),
      .rd_data   (key_rd),
      .wr_en     (key_wr_en),
      .wr_addr   (key_ff),
      .wr_data   (key_wr),
      .clear_all (key_clear)
   );

   // Queue memory: written at the tail, the head slot read on every accept.
   always_ff @(posedge clock) begin
      if (q_wr_en) begin
         q_mem[tail_ff] <= q_wr;
      end
      if (req_accept) begin
         q_rd_ff <= q_mem[head_ff];
      end
   end

   // Work stage: modify the fetched entry and decide what is written back.
   always_comb begin
      key_wr           = key_rd;
      key_wr_en        = 1'b0;
      key_clear        = 1'b0;
      q_wr_en          = 1'b0;
      mods_in          = mods_ff;
      head_in          = head_ff;
      tail_in          = tail_ff;
      last_pressed_in  = last_pressed_ff;
      last_released_in = last_released_ff;
      out_key_valid    = 1'b0;
      out_entry        = '0;
      out_count        = '0;
      unique case (act_ff)
         ACT_MAKE: begin
            last_pressed_in = key_ff;
            mods_in         = mods_ff | mod_mask(key_ff);
            if (!key_rd.pressed) begin
               key_wr.pressed    = 1'b1;
               key_wr.down_count = sat_inc(key_rd.down_count);
               key_wr_en         = 1'b1;
            end
            if ((!key_rd.pressed || repeat_en_ff) && key_ff != SC_SELF_TEST
                && ring_next(tail_ff) != head_ff) begin
               q_wr_en = 1'b1;
               tail_in = ring_next(tail_ff);
            end
         end
         ACT_BREAK: begin
            last_released_in = key_ff;
            mods_in          = mods_ff & ~mod_mask(key_ff);
            key_wr.pressed   = 1'b0;
            key_wr.up_count  = sat_inc(key_rd.up_count);
            key_wr_en        = 1'b1;
         end
         ACT_POP: begin
            if (head_ff != tail_ff) begin
               out_key_valid = 1'b1;
               out_entry     = q_rd_ff;
               head_in       = ring_next(head_ff);
            end
         end
         ACT_READ_DOWN: begin
            out_count         = key_rd.down_count;
            key_wr.down_count = '0;
            key_wr_en         = 1'b1;
         end
         ACT_READ_UP: begin
            out_count       = key_rd.up_count;
            key_wr.up_count = '0;
            key_wr_en       = 1'b1;
         end
         ACT_FLUSH: begin
            key_clear = 1'b1;
            mods_in   = '0;
            head_in   = '0;
            tail_in   = '0;
         end
         default: begin
         end
      endcase
      key_wr_en = key_wr_en & done;
      key_clear = key_clear & done;
      q_wr_en   = q_wr_en & done;
   end

   // Queue entry with the modifiers as they stand after this key.
   always_comb begin
      q_wr.ctrled  = |mods_in[5:4];
      q_wr.alted   = |mods_in[3:2];
      q_wr.shifted = |mods_in[1:0];
      q_wr.code    = key_ff;
      q_wr.stamp   = stamp_ff;
   end

   // Control state committed when the work stage finishes.
   always_ff @(posedge clock) begin
      if (reset) begin
         mods_ff          <= '0;
         head_ff          <= '0;
         tail_ff          <= '0;
         last_pressed_ff  <= '0;
         last_released_ff <= '0;
      end else if (done) begin
         mods_ff          <= mods_in;
         head_ff          <= head_in;
         tail_ff          <= tail_in;
         last_pressed_ff  <= last_pressed_in;
         last_released_ff <= last_released_in;
      end
   end

   // Result register; it holds the beat until the far side takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_key_valid_ff     <= out_key_valid;
         rsp_entry_ff         <= out_entry;
         rsp_count_ff         <= RSP_COUNT_W'(out_count);
         rsp_not_empty_ff     <= (head_in != tail_in);
         rsp_last_pressed_ff  <= last_pressed_in;
         rsp_last_released_ff <= last_released_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_key_valid         = rsp_key_valid_ff;
   assign rsp_key_code          = rsp_entry_ff.code;
   assign rsp_key_shift         = rsp_entry_ff.shifted;
   assign rsp_key_alt           = rsp_entry_ff.alted;
   assign rsp_key_ctrl          = rsp_entry_ff.ctrled;
   assign rsp_key_time          = rsp_entry_ff.stamp;
   assign rsp_count_value       = rsp_count_ff;
   assign rsp_queue_not_empty   = rsp_not_empty_ff;
   assign rsp_last_pressed_key  = rsp_last_pressed_ff;
   assign rsp_last_released_key = rsp_last_released_ff;

endmodule

`default_nettype wire

@@ src/kseq_key_store.sv @@
`default_nettype none

module kseq_key_store (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rd_en,
   input  wire logic [kseq_pkg::KEY_W-1:0]    rd_addr,
   output kseq_pkg::key_entry_type            rd_data,
   input  wire logic                          wr_en,
   input  wire logic [kseq_pkg::KEY_W-1:0]    wr_addr,
   input  kseq_pkg::key_entry_type            wr_data,
   input  wire logic                          clear_all
);
   import kseq_pkg::*;

   key_entry_type       mem [NUM_KEYS];
   key_entry_type       mem_rd_ff;
   logic                rd_valid_ff;
   logic [NUM_KEYS-1:0] valid_ff;
   logic [NUM_KEYS-1:0] valid_in;

   // Synchronous key memory, one write and one registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_rd_ff <= mem[rd_addr];
      end
   end

   // An entry becomes valid when written; a clear drops every entry at once.
   always_comb begin
      valid_in = valid_ff;
      if (clear_all) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // An entry that was never written since the last clear reads as zero.
   assign rd_data = rd_valid_ff ? mem_rd_ff : '0;

endmodule

`default_nettype wire
